// ----- rtl/cbe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, constants, command and status types of the easing core.
// ----------------------------------------------------------------------------
package cbe_pkg;

	localparam int FRAC      = 16;
	localparam int REG_W     = 19;
	localparam int T_W       = 17;
	localparam int OUT_W     = 19;
	localparam int COEF_W    = 24;
	localparam int A3_W      = 26;
	localparam int B2_W      = 25;
	localparam int S_W       = 20;
	localparam int ACC_W     = 41;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = MUL_W + S_W;
	localparam int QUO_W     = 21;
	localparam int Q_W       = QUO_W + 2;
	localparam int SN_W      = Q_W + 1;
	localparam int REM_W     = ACC_W + QUO_W - 1;
	localparam int MAX_STEPS = 5;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);
	localparam int DIVC_W    = $clog2(QUO_W);
	localparam int IDX_W     = 3;

	localparam logic signed [COEF_W-1:0] ONE_C   = COEF_W'(1 <<< FRAC);
	localparam logic signed [ACC_W-1:0]  EPS_C   = ACC_W'(((1 <<< FRAC) + 500) / 1000);
	localparam logic signed [SN_W-1:0]   S_LIM   = SN_W'(4 <<< FRAC);
	localparam logic signed [ACC_W-1:0]  OUT_MAX = ACC_W'(196608);
	localparam logic signed [ACC_W-1:0]  OUT_MIN = -ACC_W'(131072);

	localparam logic [IDX_W-1:0] REG_X1 = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_Y1 = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_X2 = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_Y2 = IDX_W'(3);

	typedef enum logic [2:0] {
		MS_AX,
		MS_ACC_BX,
		MS_ACC_CX,
		MS_A3X,
		MS_ACC_B2X,
		MS_AY,
		MS_ACC_BY,
		MS_ACC_CY
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     zcap;
		logic     dcap;
		logic     div_init;
		logic     div_step;
		logic     s_upd;
		logic     out_load;
	} cbe_cmd_t;

	typedef struct packed {
		logic z_small;
		logic d_zero;
	} cbe_stat_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
	} coef_t;

	function automatic coef_t coeffs(input logic signed [REG_W-1:0] p1,
	                                 input logic signed [REG_W-1:0] p2);
		logic signed [COEF_W-1:0] p1e;
		logic signed [COEF_W-1:0] p2e;
		logic signed [COEF_W-1:0] dif;
		coef_t r;
		p1e = COEF_W'(p1);
		p2e = COEF_W'(p2);
		dif = p2e - p1e;
		r.c = p1e + (p1e <<< 1);
		r.b = dif + (dif <<< 1) - r.c;
		r.a = ONE_C - r.c - r.b;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cbe_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_ctrl
// Sequencer: Horner multiplies, Newton steps, division and result hand-off.
// ----------------------------------------------------------------------------
module cbe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire cbe_pkg::cbe_stat_t stat,
	output cbe_pkg::cbe_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_X1, ST_X2, ST_X3, ST_ZCHK, ST_D1, ST_D2, ST_DCHK,
		ST_DIVSET, ST_DIV, ST_UPD, ST_Y1, ST_Y2, ST_Y3, ST_OUT
	} state_t;

	state_t                      state_q;
	logic [cbe_pkg::STEP_W-1:0]  step_q;
	logic [cbe_pkg::DIVC_W-1:0]  divc_q;
	logic                        out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = cbe_pkg::MS_AX;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_X1:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_AX; end
			ST_X2:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_ACC_BX; end
			ST_X3:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_ACC_CX; end
			ST_ZCHK:   cmd.zcap = 1'b1;
			ST_D1:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_A3X; end
			ST_D2:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_ACC_B2X; end
			ST_DCHK:   cmd.dcap = 1'b1;
			ST_DIVSET: cmd.div_init = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_UPD:    cmd.s_upd = 1'b1;
			ST_Y1:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_AY; end
			ST_Y2:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_ACC_BY; end
			ST_Y3:     begin cmd.mul_en = 1'b1; cmd.mul_sel = cbe_pkg::MS_ACC_CY; end
			ST_OUT:    cmd.out_load = !out_valid_q || !out_stall;
			default:   cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			divc_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= ST_X1;
					end
				end
				ST_X1:   state_q <= ST_X2;
				ST_X2:   state_q <= ST_X3;
				ST_X3:   state_q <= ST_ZCHK;
				ST_ZCHK: state_q <= stat.z_small ? ST_Y1 : ST_D1;
				ST_D1:   state_q <= ST_D2;
				ST_D2:   state_q <= ST_DCHK;
				ST_DCHK: state_q <= stat.d_zero ? ST_Y1 : ST_DIVSET;
				ST_DIVSET: begin
					divc_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					divc_q <= divc_q + 1'b1;
					if (divc_q == cbe_pkg::DIVC_W'(cbe_pkg::QUO_W - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (step_q == cbe_pkg::STEP_W'(cbe_pkg::MAX_STEPS - 1)) begin
						state_q <= ST_Y1;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_X1;
					end
				end
				ST_Y1: state_q <= ST_Y2;
				ST_Y2: state_q <= ST_Y3;
				ST_Y3: state_q <= ST_OUT;
				ST_OUT: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cbe_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_dpath
// Control registers, coefficients, shared multiplier, divider and output.
// ----------------------------------------------------------------------------
module cbe_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cbe_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [cbe_pkg::REG_W-1:0]     cfg_data,
	input  wire logic [cbe_pkg::T_W-1:0]       progress,
	input  wire cbe_pkg::cbe_cmd_t             cmd,
	output cbe_pkg::cbe_stat_t                 stat,
	output logic signed [cbe_pkg::OUT_W-1:0]   eased_value
);

	localparam int AW = cbe_pkg::ACC_W;

	logic signed [cbe_pkg::REG_W-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic signed [cbe_pkg::COEF_W-1:0] ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
	logic signed [cbe_pkg::A3_W-1:0]   a3x_q;
	logic signed [cbe_pkg::B2_W-1:0]   b2x_q;
	logic [cbe_pkg::T_W-1:0]           t_q;
	logic signed [cbe_pkg::S_W-1:0]    s_q;
	logic signed [AW-1:0]              prod_q, z_q, d_q;
	logic [cbe_pkg::REM_W-1:0]         rem_q, dsh_q;
	logic [cbe_pkg::QUO_W-1:0]         quo_q;
	logic                              neg_q, sat_q;
	logic signed [cbe_pkg::OUT_W-1:0]  eased_q;

	cbe_pkg::coef_t                    cf_x, cf_y;
	logic signed [AW-1:0]              opa, z_next, d_next, zabs, dabs, y_sat;
	logic signed [cbe_pkg::MUL_W-1:0]  opa_m;
	logic signed [cbe_pkg::PROD_W-1:0] prod_full;
	logic signed [cbe_pkg::Q_W-1:0]    qmag, qs;
	logic signed [cbe_pkg::SN_W-1:0]   s_new, s_clamp;

	assign cf_x = cbe_pkg::coeffs(x1_q, x2_q);
	assign cf_y = cbe_pkg::coeffs(y1_q, y2_q);

	always_comb begin
		case (cmd.mul_sel)
			cbe_pkg::MS_AX:      opa = AW'(ax_q);
			cbe_pkg::MS_ACC_BX:  opa = prod_q + AW'(bx_q);
			cbe_pkg::MS_ACC_CX:  opa = prod_q + AW'(cx_q);
			cbe_pkg::MS_A3X:     opa = AW'(a3x_q);
			cbe_pkg::MS_ACC_B2X: opa = prod_q + AW'(b2x_q);
			cbe_pkg::MS_AY:      opa = AW'(ay_q);
			cbe_pkg::MS_ACC_BY:  opa = prod_q + AW'(by_q);
			cbe_pkg::MS_ACC_CY:  opa = prod_q + AW'(cy_q);
			default:             opa = '0;
		endcase
	end

	assign opa_m        = cbe_pkg::MUL_W'(opa);
	assign prod_full    = opa_m * s_q;
	assign z_next       = prod_q - AW'($signed({1'b0, t_q}));
	assign d_next       = prod_q + AW'(cx_q);
	assign stat.z_small = (z_next > -cbe_pkg::EPS_C) && (z_next < cbe_pkg::EPS_C);
	assign stat.d_zero  = (d_next == '0);

	assign zabs = z_q[AW-1] ? -z_q : z_q;
	assign dabs = d_q[AW-1] ? -d_q : d_q;

	assign qmag    = sat_q ? cbe_pkg::Q_W'(1 <<< cbe_pkg::QUO_W)
	                       : cbe_pkg::Q_W'({1'b0, quo_q});
	assign qs      = neg_q ? -qmag : qmag;
	assign s_new   = cbe_pkg::SN_W'(s_q) - cbe_pkg::SN_W'(qs);
	assign s_clamp = (s_new > cbe_pkg::S_LIM) ? cbe_pkg::S_LIM :
	                 (s_new < -cbe_pkg::S_LIM) ? -cbe_pkg::S_LIM : s_new;

	assign y_sat = (prod_q > cbe_pkg::OUT_MAX) ? cbe_pkg::OUT_MAX :
	               (prod_q < cbe_pkg::OUT_MIN) ? cbe_pkg::OUT_MIN : prod_q;

	assign eased_value = eased_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= cbe_pkg::REG_W'(16384);
			y1_q <= cbe_pkg::REG_W'(6554);
			x2_q <= cbe_pkg::REG_W'(16384);
			y2_q <= cbe_pkg::REG_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbe_pkg::REG_X1: x1_q <= cfg_data;
				cbe_pkg::REG_Y1: y1_q <= cfg_data;
				cbe_pkg::REG_X2: x2_q <= cfg_data;
				cbe_pkg::REG_Y2: y2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q   <= progress;
			s_q   <= cbe_pkg::S_W'({1'b0, progress});
			ax_q  <= cf_x.a;
			bx_q  <= cf_x.b;
			cx_q  <= cf_x.c;
			ay_q  <= cf_y.a;
			by_q  <= cf_y.b;
			cy_q  <= cf_y.c;
			a3x_q <= cbe_pkg::A3_W'(cf_x.a) + (cbe_pkg::A3_W'(cf_x.a) <<< 1);
			b2x_q <= cbe_pkg::B2_W'(cf_x.b) <<< 1;
		end
		if (cmd.mul_en) begin
			prod_q <= AW'(prod_full >>> cbe_pkg::FRAC);
		end
		if (cmd.zcap) begin
			z_q <= z_next;
		end
		if (cmd.dcap) begin
			d_q <= d_next;
		end
		if (cmd.div_init) begin
			neg_q <= z_q[AW-1] ^ d_q[AW-1];
			sat_q <= (AW'(unsigned'(zabs)) >> 5) >= unsigned'(dabs);
			rem_q <= cbe_pkg::REM_W'({zabs, {cbe_pkg::FRAC{1'b0}}});
			dsh_q <= cbe_pkg::REM_W'({dabs, {(cbe_pkg::QUO_W - 1){1'b0}}});
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[cbe_pkg::QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[cbe_pkg::QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.s_upd) begin
			s_q <= cbe_pkg::S_W'(s_clamp);
		end
		if (cmd.out_load) begin
			eased_q <= cbe_pkg::OUT_W'(y_sat);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cubic_bezier_easing_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_easing_core
// Cubic Bezier timing curve: maps progress t to eased y via Newton search.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, progress) takes one item while the core
// is idle; in_stall stays high while an item is being worked on.
// Output channel (out_valid/out_stall, eased_value) carries one result per
// item from an output register, so a new item is taken while it waits.
// Sequence: 3 multiplies plus a check for x(s), then per Newton step 2
// multiplies, a check, a setup, a 21-bit bit-serial division and an update;
// then 3 multiplies for y(s) and one to load. An item may exit early, else
// it runs five full steps; the shared multiplier and the one-bit-per-cycle
// divider set its duration.
// The user writes control points over cfg_we/cfg_index/cfg_data only while
// idle; not enforced by the core. Reset restores defaults, empties output reg.
// A stalled result holds in the output register; one more item may complete
// its work and then waits in the core until the register frees.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [cbe_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [cbe_pkg::REG_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [cbe_pkg::T_W-1:0]      progress,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [cbe_pkg::OUT_W-1:0]  eased_value
);

	cbe_pkg::cbe_cmd_t  cmd;
	cbe_pkg::cbe_stat_t stat;

	cbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbe_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.progress    (progress),
		.cmd         (cmd),
		.stat        (stat),
		.eased_value (eased_value)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("core took an item but did not go busy");

	a_result_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in flight");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
